@@ rtl/core/tts_pkg.sv @@
// types and constants shared by the tick task scheduler table
// no dependencies
package tts_pkg;

  localparam int HANDLE_W = 8;
  localparam int STEP_W   = 16;
  localparam int PEND_W   = 8;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] ADDR_TICK_STEP = 3'd0;
  localparam logic [STEP_W-1:0]  STEP_RESET     = 16'd1;
  localparam logic [PEND_W-1:0]  PEND_MAX       = 8'hFF;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_TASK = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_REPLY = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    CMD_HOLD = 3'd0,
    CMD_LOAD = 3'd1,
    CMD_TAKE = 3'd2,
    CMD_TICK = 3'd3,
    CMD_DEC  = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [STEP_W-1:0]     step;
    logic [HANDLE_W-1:0]   load_handle;
  } cell_ctrl_t;

endpackage

@@ rtl/core/tts_cell.sv @@
// one table entry: handle, delay, period and pending runs
// loads, ticks, decrements or takes the entry of its upper neighbor; uses tts_pkg
module tts_cell #(
  parameter int TIME_BITS = 32
) (
  input  logic                         clk,
  input  tts_pkg::cell_ctrl_t          ctrl,
  input  logic [TIME_BITS-1:0]         load_delay,
  input  logic [TIME_BITS-1:0]         load_period,
  input  logic [tts_pkg::HANDLE_W-1:0] nb_handle,
  input  logic [TIME_BITS-1:0]         nb_delay,
  input  logic [TIME_BITS-1:0]         nb_period,
  input  logic [tts_pkg::PEND_W-1:0]   nb_pending,
  output logic [tts_pkg::HANDLE_W-1:0] handle,
  output logic [TIME_BITS-1:0]         delay,
  output logic [TIME_BITS-1:0]         period,
  output logic [tts_pkg::PEND_W-1:0]   pending
);
  import tts_pkg::*;

  logic [31:0]          delay_wide;
  logic [31:0]          step_wide;
  logic [TIME_BITS-1:0] delay_dec;

  assign delay_wide = 32'(delay);
  assign step_wide  = 32'(ctrl.step);
  assign delay_dec  = (delay_wide > step_wide) ? TIME_BITS'(delay_wide - step_wide) : '0;

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_LOAD: begin
        handle  <= ctrl.load_handle;
        delay   <= load_delay;
        period  <= load_period;
        pending <= '0;
      end
      CMD_TAKE: begin
        handle  <= nb_handle;
        delay   <= nb_delay;
        period  <= nb_period;
        pending <= nb_pending;
      end
      CMD_TICK: begin
        if (delay != '0) begin
          delay <= delay_dec;
        end else begin
          if (pending != PEND_MAX) begin
            pending <= pending + PEND_W'(1);
          end
          if (period != '0) begin
            delay <= period;
          end
        end
      end
      CMD_DEC: begin
        pending <= pending - PEND_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/tick_task_scheduler_table_top.sv @@
// tick task scheduler table: row of entry cells, sequencer, dispatch word buffer
// add, delete, tick: accepted in idle, executed next cycle, word registered in S_REPLY once the output is free
// dispatch: scan of one entry per cycle, then one word per cycle while the output is free
// one item in flight at a time; input ready only while idle
// reset clears task count, tick_step to 1 and result_valid; entry contents are not cleared
// depends on tts_pkg and tts_cell
module tick_task_scheduler_table_top #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [1:0]                    operation,
  input  logic [tts_pkg::HANDLE_W-1:0]  task_handle,
  input  logic [31:0]                   start_delay,
  input  logic [31:0]                   repeat_period,
  input  logic [3:0]                    slot,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    reply_kind,
  output logic [1:0]                    status,
  output logic [4:0]                    task_total,
  output logic [tts_pkg::HANDLE_W-1:0]  run_handle,
  output logic                          has_task,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tts_pkg::PADDR_W-1:0]   paddr,
  input  logic [tts_pkg::PDATA_W-1:0]   pwdata,
  output logic [tts_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import tts_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     rd;
  logic [STEP_W-1:0]    tick_step;

  op_t                  op_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [TIME_BITS-1:0] delay_q;
  logic [TIME_BITS-1:0] period_q;
  logic [3:0]           slot_q;
  logic [1:0]           rep_kind;
  status_t              rep_status;
  logic [CNT_W-1:0]     rep_total;

  logic [HANDLE_W-1:0]  run_buf [MAX_TASKS];

  logic [HANDLE_W-1:0]  c_handle  [MAX_TASKS];
  logic [TIME_BITS-1:0] c_delay   [MAX_TASKS];
  logic [TIME_BITS-1:0] c_period  [MAX_TASKS];
  logic [PEND_W-1:0]    c_pending [MAX_TASKS];

  logic [HANDLE_W-1:0]  sel_handle;
  logic [TIME_BITS-1:0] sel_period;
  logic [PEND_W-1:0]    sel_pending;
  logic                 scan_more;
  logic                 take_hit;
  logic                 scan_drop;
  logic                 slot_ok;
  logic                 table_full;
  logic                 out_free;
  logic                 emit_last;
  logic                 item_acc;
  logic                 cfg_wr;

  assign item_ready  = (state == S_IDLE);
  assign item_acc    = item_valid && item_ready;
  assign out_free    = !result_valid || result_ready;
  assign sel_handle  = c_handle[idx[IDX_W-1:0]];
  assign sel_period  = c_period[idx[IDX_W-1:0]];
  assign sel_pending = c_pending[idx[IDX_W-1:0]];
  assign scan_more   = idx < count;
  assign take_hit    = scan_more && (sel_pending != '0);
  assign scan_drop   = take_hit && (sel_period == '0);
  assign slot_ok     = 32'(slot_q) < 32'(count);
  assign table_full  = count >= CNT_W'(MAX_TASKS);
  assign emit_last   = (rd + CNT_W'(1)) == n;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TICK_STEP);
  assign prdata = (paddr == ADDR_TICK_STEP) ? PDATA_W'(tick_step) : '0;

  // row of entry cells
  for (genvar j = 0; j < MAX_TASKS; j++) begin : g_cell
    cell_cmd_t            cmd;
    cell_ctrl_t           ctrl;
    logic [HANDLE_W-1:0]  nb_handle;
    logic [TIME_BITS-1:0] nb_delay;
    logic [TIME_BITS-1:0] nb_period;
    logic [PEND_W-1:0]    nb_pending;

    always_comb begin
      cmd = CMD_HOLD;
      case (state)
        S_EXEC: begin
          case (op_q)
            OP_ADD: begin
              if (!table_full && (count == CNT_W'(j))) cmd = CMD_LOAD;
            end
            OP_DELETE: begin
              if (slot_ok && (32'(j) >= 32'(slot_q)) && (32'(j) + 32'd1 < 32'(count)))
                cmd = CMD_TAKE;
            end
            OP_TICK: begin
              if (CNT_W'(j) < count) cmd = CMD_TICK;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (scan_drop) begin
            if ((32'(j) >= 32'(idx)) && (32'(j) + 32'd1 < 32'(count))) cmd = CMD_TAKE;
          end else if (take_hit && (idx == CNT_W'(j))) begin
            cmd = CMD_DEC;
          end
        end
        default: begin
        end
      endcase
    end

    assign ctrl = '{cmd: cmd, step: tick_step, load_handle: handle_q};

    if (j < MAX_TASKS - 1) begin : g_nb
      assign nb_handle  = c_handle[j+1];
      assign nb_delay   = c_delay[j+1];
      assign nb_period  = c_period[j+1];
      assign nb_pending = c_pending[j+1];
    end else begin : g_end
      assign nb_handle  = c_handle[j];
      assign nb_delay   = c_delay[j];
      assign nb_period  = c_period[j];
      assign nb_pending = c_pending[j];
    end

    tts_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .load_delay  (delay_q),
      .load_period (period_q),
      .nb_handle   (nb_handle),
      .nb_delay    (nb_delay),
      .nb_period   (nb_period),
      .nb_pending  (nb_pending),
      .handle      (c_handle[j]),
      .delay       (c_delay[j]),
      .period      (c_period[j]),
      .pending     (c_pending[j])
    );
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      idx          <= '0;
      n            <= '0;
      rd           <= '0;
      tick_step    <= STEP_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        tick_step <= pwdata[STEP_W-1:0];
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc) state <= S_EXEC;
        end
        S_EXEC: begin
          case (op_q)
            OP_ADD: begin
              if (!table_full) count <= count + CNT_W'(1);
              state <= S_REPLY;
            end
            OP_DELETE: begin
              if (slot_ok) count <= count - CNT_W'(1);
              state <= S_REPLY;
            end
            OP_TICK: begin
              state <= S_REPLY;
            end
            default: begin
              idx   <= '0;
              n     <= '0;
              state <= S_SCAN;
            end
          endcase
        end
        S_SCAN: begin
          if (scan_more) begin
            if (take_hit) n <= n + CNT_W'(1);
            if (scan_drop) begin
              count <= count - CNT_W'(1);
            end else begin
              idx <= idx + CNT_W'(1);
            end
          end else if (n == '0) begin
            state <= S_REPLY;
          end else begin
            rd    <= '0;
            state <= S_EMIT;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            rd           <= rd + CNT_W'(1);
            if (emit_last) state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // input latch, reply fields, dispatch buffer and output word
  always_ff @(posedge clk) begin
    if (item_acc) begin
      op_q     <= op_t'(operation);
      handle_q <= task_handle;
      delay_q  <= start_delay[TIME_BITS-1:0];
      period_q <= repeat_period[TIME_BITS-1:0];
      slot_q   <= slot;
    end
    if (state == S_EXEC) begin
      rep_kind <= op_q;
      case (op_q)
        OP_ADD: begin
          rep_status <= table_full ? ST_FULL : ST_OK;
          rep_total  <= table_full ? '0 : count + CNT_W'(1);
        end
        OP_DELETE: begin
          rep_status <= slot_ok ? ST_OK : ST_NO_TASK;
          rep_total  <= slot_ok ? count - CNT_W'(1) : '0;
        end
        default: begin
          rep_status <= ST_OK;
          rep_total  <= count;
        end
      endcase
    end
    if ((state == S_SCAN) && !scan_more) begin
      rep_total <= count;
    end
    if ((state == S_SCAN) && take_hit) begin
      run_buf[n[IDX_W-1:0]] <= sel_handle;
    end
    if ((state == S_REPLY) && out_free) begin
      reply_kind <= rep_kind;
      status     <= rep_status;
      task_total <= 5'(rep_total);
      run_handle <= '0;
      has_task   <= 1'b0;
      last       <= 1'b1;
    end
    if ((state == S_EMIT) && out_free) begin
      reply_kind <= OP_DISPATCH;
      status     <= ST_OK;
      task_total <= 5'(count);
      run_handle <= run_buf[rd[IDX_W-1:0]];
      has_task   <= 1'b1;
      last       <= emit_last;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_TASKS)
    else $error("task count beyond table size");

  a_state_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_task_kind : assert property (@(posedge clk) disable iff (rst)
    (result_valid && has_task) |-> (reply_kind == OP_DISPATCH))
    else $error("task word on a non-dispatch reply");

  a_error_word : assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != ST_OK)) |-> ((task_total == 5'd0) && last))
    else $error("error reply with nonzero total or not last");

endmodule
